// ===== sv/spr_pkg.sv =====
// Shared types and register codes for the stream pattern replacer.
`default_nettype none
package spr_pkg;

  localparam int unsigned ByteW = 8;

  // One result entry: data byte, data-present flag, end-of-string flag.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             valid;
    logic             last;
  } res_t;

  // Register index = paddr[4:3].
  typedef enum logic [1:0] {
    REG_PATTERN_LEN   = 2'd0,
    REG_PATTERN_BYTES = 2'd1,
    REG_REPLACE_LEN   = 2'd2,
    REG_REPLACE_BYTES = 2'd3
  } reg_idx_e;

endpackage
`default_nettype wire

// ===== sv/spr_win_cell.sv =====
// One window cell: holds a pending byte, compares it, passes it to its neighbor.
`default_nettype none
module spr_win_cell (
  input  wire logic                    clk_i,
  input  wire logic                    upd_i,      // item accepted
  input  wire logic                    wr_here_i,  // new byte lands in this cell
  input  wire logic                    shift_i,    // take the right neighbor's byte
  input  wire logic [spr_pkg::ByteW-1:0] byte_i,   // incoming stream byte
  input  wire logic [spr_pkg::ByteW-1:0] nbr_i,    // right neighbor's current byte
  input  wire logic [spr_pkg::ByteW-1:0] pat_i,    // pattern byte for this slot
  output logic      [spr_pkg::ByteW-1:0] cur_o,    // byte in this slot after insert
  output logic                         eq_o
);
  import spr_pkg::*;

  logic [ByteW-1:0] store_q, store_d;

  assign cur_o = wr_here_i ? byte_i : store_q;
  assign eq_o  = (cur_o == pat_i);

  always_comb begin
    store_d = store_q;
    if (upd_i) begin
      store_d = shift_i ? nbr_i : cur_o;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

endmodule
`default_nettype wire

// ===== sv/spr_emit.sv =====
// Result buffer: takes a burst of results and plays them out through an output register.
`default_nettype none
module spr_emit #(
  parameter int unsigned Depth = 8,
  parameter int unsigned CntW  = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  spr_pkg::res_t          burst_i [Depth],
  input  wire logic [CntW-1:0]   cnt_i,
  output logic                   empty_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
  output logic                   m_axis_tuser,   // [0] byte_valid
  output logic                   m_axis_tlast    // out_last
);
  import spr_pkg::*;

  res_t            buf_q [Depth];
  res_t            buf_d [Depth];
  logic [CntW-1:0] cnt_q, cnt_d;
  res_t            out_q, out_d;
  logic            out_vld_q, out_vld_d;
  logic            out_free;

  assign out_free = !out_vld_q || m_axis_tready;
  assign empty_o  = (cnt_q == '0);

  always_comb begin
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    if (load_i) begin
      if ((cnt_i != '0) && out_free) begin
        // head goes straight to the output register
        out_d     = burst_i[0];
        out_vld_d = 1'b1;
        for (int i = 0; i < Depth - 1; i++) begin
          buf_d[i] = burst_i[i+1];
        end
        buf_d[Depth-1] = '0;
        cnt_d = cnt_i - CntW'(1);
      end else begin
        buf_d = burst_i;
        cnt_d = cnt_i;
      end
    end else if ((cnt_q != '0) && out_free) begin
      out_d     = buf_q[0];
      out_vld_d = 1'b1;
      for (int i = 0; i < Depth - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      buf_d[Depth-1] = '0;
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.valid;
  assign m_axis_tlast  = out_q.last;

endmodule
`default_nettype wire

// ===== sv/stream_pattern_replace_top.sv =====
// Top level: streaming find-and-replace of a fixed byte pattern.
//
//  channel   | dir | handshake                 | content
//  ----------+-----+---------------------------+------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready      | tdata[7:0] data_byte, tlast end_of_string
//  m_axis    | out | m_axis_tvalid/tready      | tdata[7:0] out_byte, tuser byte_valid,
//            |     |                           | tlast out_last
//  apb cfg   | in  | psel/penable/pwrite       | 64-bit regs at 0x00,0x08,0x10,0x18
//
// Rate: an item that yields at most one result is taken every cycle while the
// output register is not stalled. An item that yields n results (a replacement
// or an end-of-string flush, n <= 8) stalls the input until the result buffer
// drains, so its throughput is set by the one-result-per-cycle output register.
// Reset: window fill, result count and output valid clear; registers read 0.
// Stalls: a held m_axis_tready fills the output register, then the result
// buffer; s_axis_tready drops once the buffer is not empty.
`default_nettype none
module stream_pattern_replace_top #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_string
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tuser,   // [0] byte_valid
  output logic             m_axis_tlast,   // out_last
  // config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import spr_pkg::*;

  // Window cells in use and replacement bytes that can be emitted; both are
  // capped at 8 by the packed 64-bit registers.
  localparam int unsigned WinD     = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;
  localparam int unsigned RepD     = (REPLACE_MAX < 8) ? REPLACE_MAX : 8;
  localparam int unsigned BufDepth = (WinD > RepD) ? WinD : RepD;
  localparam int unsigned CntW     = $clog2(BufDepth + 1);
  localparam logic [3:0]  WinDL    = 4'(WinD);
  localparam logic [3:0]  RepDL    = 4'(RepD);

  // ---------------- configuration registers ----------------
  logic [3:0]  pat_len_q, pat_len_d;
  logic [63:0] pat_bytes_q, pat_bytes_d;
  logic [3:0]  rep_len_q, rep_len_d;
  logic [63:0] rep_bytes_q, rep_bytes_d;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:3]);

  always_comb begin
    pat_len_d   = pat_len_q;
    pat_bytes_d = pat_bytes_q;
    rep_len_d   = rep_len_q;
    rep_bytes_d = rep_bytes_q;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_LEN:   pat_len_d   = pwdata[3:0];
        REG_PATTERN_BYTES: pat_bytes_d = pwdata;
        REG_REPLACE_LEN:   rep_len_d   = pwdata[3:0];
        REG_REPLACE_BYTES: rep_bytes_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_LEN:   prdata = {60'd0, pat_len_q};
      REG_PATTERN_BYTES: prdata = pat_bytes_q;
      REG_REPLACE_LEN:   prdata = {60'd0, rep_len_q};
      REG_REPLACE_BYTES: prdata = rep_bytes_q;
      default:           prdata = '0;
    endcase
  end

  // ---------------- effective lengths ----------------
  logic [3:0] p_len, r_len;
  assign p_len = (pat_len_q > WinDL) ? WinDL : pat_len_q;
  assign r_len = (rep_len_q > RepDL) ? RepDL : rep_len_q;

  // ---------------- window cell chain ----------------
  logic             acc;
  logic [3:0]       fill_q, fill_d;
  logic             full, hit, shift;
  logic [ByteW-1:0] cur   [WinD];
  logic [WinD-1:0]  eq_m;

  assign acc   = s_axis_tvalid && s_axis_tready;
  assign full  = (4'(fill_q + 4'd1) == p_len);
  assign hit   = (p_len != 4'd0) && full && (&eq_m);
  // a miss on a full window drops the oldest byte and shifts the chain
  assign shift = (p_len != 4'd0) && full && !hit;

  for (genvar i = 0; i < WinD; i++) begin : g_cell
    logic [ByteW-1:0] nbr;
    logic             eq_raw;
    if (i == WinD - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cur[i+1];
    end
    spr_win_cell u_cell (
      .clk_i     (clk_i),
      .upd_i     (acc),
      .wr_here_i (fill_q == 4'(i)),
      .shift_i   (shift),
      .byte_i    (s_axis_tdata),
      .nbr_i     (nbr),
      .pat_i     (pat_bytes_q[8*i +: 8]),
      .cur_o     (cur[i]),
      .eq_o      (eq_raw)
    );
    // slots past the pattern length always agree
    assign eq_m[i] = eq_raw || (4'(i) >= p_len);
  end

  always_comb begin
    fill_d = fill_q;
    if (cfg_wr && (cfg_idx == REG_PATTERN_LEN)) begin
      fill_d = 4'd0;
    end else if (acc && (p_len != 4'd0)) begin
      if (hit || s_axis_tlast) begin
        fill_d = 4'd0;
      end else if (!full) begin
        fill_d = 4'(fill_q + 4'd1);
      end
    end
  end

  // ---------------- burst assembly ----------------
  logic [ByteW-1:0] cur_pad [BufDepth];
  logic [ByteW-1:0] rep_pad [BufDepth];

  for (genvar i = 0; i < BufDepth; i++) begin : g_pad
    if (i < WinD) begin : g_w
      assign cur_pad[i] = cur[i];
    end else begin : g_wz
      assign cur_pad[i] = '0;
    end
    if (i < RepD) begin : g_r
      assign rep_pad[i] = rep_bytes_q[8*i +: 8];
    end else begin : g_rz
      assign rep_pad[i] = '0;
    end
  end

  logic [CntW-1:0] n_raw, n_out, n_m1;
  logic            marker;
  res_t            burst [BufDepth];

  always_comb begin
    if (p_len == 4'd0) begin
      n_raw = CntW'(1);
    end else if (hit) begin
      n_raw = CntW'(r_len);
    end else if (s_axis_tlast) begin
      n_raw = CntW'(fill_q + 4'd1);   // window plus new byte, flushed
    end else if (full) begin
      n_raw = CntW'(1);
    end else begin
      n_raw = '0;
    end
  end

  // end of string with nothing to send still carries one marker result
  assign marker = s_axis_tlast && (n_raw == '0);
  assign n_out  = marker ? CntW'(1) : n_raw;
  assign n_m1   = n_out - CntW'(1);

  always_comb begin
    for (int i = 0; i < BufDepth; i++) begin
      if (marker) begin
        burst[i].data  = '0;
        burst[i].valid = 1'b0;
      end else if (p_len == 4'd0) begin
        burst[i].data  = s_axis_tdata;
        burst[i].valid = 1'b1;
      end else if (hit) begin
        burst[i].data  = rep_pad[i];
        burst[i].valid = 1'b1;
      end else begin
        burst[i].data  = cur_pad[i];
        burst[i].valid = 1'b1;
      end
      burst[i].last = s_axis_tlast && (CntW'(i) == n_m1);
    end
  end

  // ---------------- result buffer and output register ----------------
  logic emit_empty;

  spr_emit #(
    .Depth (BufDepth),
    .CntW  (CntW)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (acc),
    .burst_i       (burst),
    .cnt_i         (n_out),
    .empty_o       (emit_empty),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Ready depends only on registered buffer state.
  assign s_axis_tready = emit_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      pat_bytes_q <= '0;
      rep_len_q   <= '0;
      rep_bytes_q <= '0;
      fill_q      <= '0;
    end else begin
      pat_len_q   <= pat_len_d;
      pat_bytes_q <= pat_bytes_d;
      rep_len_q   <= rep_len_d;
      rep_bytes_q <= rep_bytes_d;
      fill_q      <= fill_d;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_stream_pattern_replace_top.sv =====
// Testbench for stream_pattern_replace_top: random strings checked against a find-and-replace predictor.
module tb_stream_pattern_replace_top;
  import spr_pkg::*;

  localparam int unsigned PatternMax   = 8;
  localparam int unsigned ReplaceMax   = 8;
  localparam int unsigned RandomItems  = 260;
  // cycles allowed after the last expected result before touching registers
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned HoldCycles   = 96;

  // Predictor plus store of the rewritten bytes still owed by the block.
  class rewrite_scoreboard;
    logic [3:0]  pat_len;
    logic [3:0]  rep_len;
    logic [63:0] pat_word;
    logic [63:0] rep_word;
    logic [7:0]  window[PatternMax];
    int unsigned fill;
    res_t        step_q[$];
    res_t        rewritten_q[$];
    int unsigned errors;

    function new();
      pat_len  = '0;
      rep_len  = '0;
      pat_word = '0;
      rep_word = '0;
      fill     = 0;
      errors   = 0;
    endfunction

    // length in use: saturated to the parameter and to the 8 packed bytes
    function int unsigned sat_len(logic [3:0] len, int unsigned lim);
      int unsigned n;
      n = len;
      if (n > lim) n = lim;
      if (n > 8) n = 8;
      return n;
    endfunction

    function void emit(logic [7:0] b);
      res_t e;
      e.data  = b;
      e.valid = 1'b1;
      e.last  = 1'b0;
      step_q.push_back(e);
    endfunction

    function void set_reg(reg_idx_e idx, logic [63:0] v);
      case (idx)
        REG_PATTERN_LEN: begin
          pat_len = v[3:0];
          fill    = 0;      // any pattern length write drops pending bytes
        end
        REG_PATTERN_BYTES: pat_word = v;
        REG_REPLACE_LEN:   rep_len  = v[3:0];
        REG_REPLACE_BYTES: rep_word = v;
        default: ;
      endcase
    endfunction

    // Accepted input byte: append the results it causes.
    function void note_byte(logic [7:0] b, logic last);
      int unsigned p;
      int unsigned r;
      bit          hit;
      res_t        e;
      p = sat_len(pat_len, PatternMax);
      r = sat_len(rep_len, ReplaceMax);
      step_q.delete();
      if (p == 0) begin
        emit(b);
      end else begin
        window[fill] = b;
        fill++;
        if (fill == p) begin
          hit = 1'b1;
          for (int i = 0; i < p; i++) begin
            if (window[i] != pat_word[8*i +: 8]) hit = 1'b0;
          end
          if (hit) begin
            for (int i = 0; i < r; i++) emit(rep_word[8*i +: 8]);
            fill = 0;
          end else begin
            emit(window[0]);
            for (int i = 0; i + 1 < p; i++) window[i] = window[i+1];
            fill = p - 1;
          end
        end
        if (last) begin
          for (int i = 0; i < fill; i++) emit(window[i]);
          fill = 0;
        end
      end
      if (last) begin
        if (step_q.size() == 0) begin
          e.data  = 8'h00;
          e.valid = 1'b0;
          e.last  = 1'b1;
        end else begin
          e      = step_q.pop_back();
          e.last = 1'b1;
        end
        step_q.push_back(e);
      end
      foreach (step_q[i]) rewritten_q.push_back(step_q[i]);
    endfunction

    function void check_out(res_t got);
      res_t want;
      if (rewritten_q.size() == 0) begin
        $display("%0t: unexpected result: data %02h valid %0b last %0b",
                 $time, got.data, got.valid, got.last);
        errors++;
        return;
      end
      want = rewritten_q.pop_front();
      if (got.data !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, got.data);
        errors++;
      end
      if (got.valid !== want.valid) begin
        $display("%0t: byte_valid expected %0b actual %0b", $time, want.valid, got.valid);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: out_last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  wire         s_ready;
  logic [7:0]  s_data  = 8'h00;
  logic        s_last  = 1'b0;
  wire         m_valid;
  logic        m_ready = 1'b0;
  wire  [7:0]  m_data;
  wire         m_user;
  wire         m_last;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [63:0] pwdata  = '0;
  wire  [63:0] prdata;
  wire         pready;

  bit          calm      = 1'b0;  // no idling on either side while set
  bit          hold_req  = 1'b0;  // asks the receiver for one long hold-off
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;

  rewrite_scoreboard sb = new();

  stream_pattern_replace_top #(
    .PATTERN_MAX(PatternMax),
    .REPLACE_MAX(ReplaceMax)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),   // [7:0] data_byte
    .s_axis_tlast (s_last),   // end_of_string
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),   // [7:0] out_byte
    .m_axis_tuser (m_user),   // [0] byte_valid
    .m_axis_tlast (m_last),   // out_last
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, or one long hold-off counted here so the block
  // backs up into its input while the sender keeps offering items.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (calm) begin
      m_ready <= 1'b1;
    end else begin
      m_ready <= ($urandom_range(99) >= 16);
    end
  end

  // Output monitor: every accepted result goes against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_out(res_t'{m_data, m_user, m_last});
  end

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 16) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sb.note_byte(b, last);
    items_sent++;
  endtask

  // Stop offering, let every expected result come out, then let the block settle.
  task automatic pause_until_drained();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.rewritten_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_idx_e idx, logic [63:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [3:0] plen, logic [63:0] pword,
                           logic [3:0] rlen, logic [63:0] rword);
    pause_until_drained();
    write_reg(REG_PATTERN_BYTES, pword);
    write_reg(REG_REPLACE_LEN, {60'd0, rlen});
    write_reg(REG_REPLACE_BYTES, rword);
    write_reg(REG_PATTERN_LEN, {60'd0, plen});
  endtask

  // String built to hit the pattern often: whole copies, broken prefixes,
  // loose pattern bytes, and some fully random bytes. close=0 leaves it open.
  task automatic send_string(int unsigned len, bit close);
    logic [7:0]  s[$];
    int unsigned p;
    int unsigned k;
    int unsigned cut;
    p = (sb.pat_len > PatternMax) ? PatternMax : sb.pat_len;
    while (s.size() < len) begin
      k = $urandom_range(99);
      if (p != 0 && k < 40) begin
        cut = (k < 30) ? p : $urandom_range(p, 1);
        for (int i = 0; i < cut; i++) s.push_back(sb.pat_word[8*i +: 8]);
      end else if (p != 0 && k < 75) begin
        s.push_back(sb.pat_word[8*$urandom_range(p-1) +: 8]);
      end else begin
        s.push_back(8'($urandom_range(255)));
      end
    end
    foreach (s[i]) send_byte(s[i], close && (i == s.size() - 1));
  endtask

  initial begin
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [63:0] pword;
    logic [63:0] rword;
    int unsigned phase;
    int unsigned nstr;
    int unsigned directed_n;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers come up zero: bytes pass straight through, extremes first.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Pattern "AB" -> "xyz"; trailing C is flushed as the last byte.
    configure(4'd2, 64'h4241, 4'd3, 64'h7A7978);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b1);
    // partial window flushed at end of string
    send_byte(8'h41, 1'b1);

    // Empty replacement: a match on the final byte leaves only the end marker.
    pause_until_drained();
    write_reg(REG_REPLACE_LEN, 64'd0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);

    // Writing the pattern length drops the pending A, so B alone is no match.
    send_byte(8'h41, 1'b0);
    pause_until_drained();
    write_reg(REG_PATTERN_LEN, 64'd2);
    send_byte(8'h42, 1'b1);

    // Both lengths above the limit: saturate to 8 bytes each.
    configure(4'hF, 64'h00FF_807F_01FE_AA55, 4'hF, 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 8; i++) send_byte(sb.pat_word[8*i +: 8], i == 7);

    directed_n = items_sent;

    // Random phases: settings at the extremes first, then random ones.
    phase = 0;
    while (items_sent < directed_n + RandomItems) begin
      pword = {$urandom, $urandom};
      rword = {$urandom, $urandom};
      case (phase)
        0: begin plen = 4'd0; rlen = 4'd0; end
        1: begin plen = 4'd1; rlen = 4'd8; end
        2: begin plen = 4'd2; rlen = 4'd8; end
        3: begin plen = 4'd8; rlen = 4'd0; end
        4: begin plen = 4'hF; rlen = 4'hF; end
        5: begin plen = 4'd3; rlen = 4'd2; end
        6: begin plen = 4'd1; rlen = 4'd0; end
        default: begin
          plen = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4, 1));
          rlen = 4'($urandom_range(15));
          // repeated byte checks that matches do not overlap
          if ($urandom_range(3) == 0) pword = {8{8'($urandom_range(255))}};
        end
      endcase
      configure(plen, pword, rlen, rword);
      calm = (phase == 1);
      nstr = $urandom_range(6, 3);
      for (int j = 0; j < nstr; j++) begin
        if (phase == 2 && j == 0) hold_req = 1'b1;
        // now and then a string is left open across the next register write
        send_string($urandom_range(16, 1), !(j == nstr - 1 && $urandom_range(3) == 0));
        // keep offering through the hold-off phase so the block backs up
        if (phase != 2 && $urandom_range(5) == 0) pause_until_drained();
      end
      calm = 1'b0;
      phase++;
    end

    pause_until_drained();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
